@@ rtl/pidl_pkg.sv @@
// ============================================================================
// pidl_pkg
// Shared codes and types for the positional insert/delete list unit.
// ============================================================================
package pidl_pkg;

    localparam int unsigned ID_W     = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCOUNT_W = 9;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT2 = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE2 = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // cell modes broadcast along the row
    localparam logic [2:0] CM_HOLD = 3'd0;
    localparam logic [2:0] CM_INS1 = 3'd1;
    localparam logic [2:0] CM_INS2 = 3'd2;
    localparam logic [2:0] CM_DEL1 = 3'd3;
    localparam logic [2:0] CM_DEL2 = 3'd4;

    typedef struct packed {
        logic [2:0]      mode;
        logic [ID_W-1:0] id1;
        logic [ID_W-1:0] id2;
    } t_cell_ctl;

endpackage

@@ rtl/pidl_cell.sv @@
// ============================================================================
// pidl_cell
// One storage cell of the list row; loads from a neighbor or a new id.
// ============================================================================
module pidl_cell #(
    parameter int unsigned CW  = 9,
    parameter int unsigned IDX = 0
) (
    input  logic                          i_clk,
    input  pidl_pkg::t_cell_ctl           i_ctl,
    input  logic [CW-1:0]                 i_at,
    input  logic [pidl_pkg::POS_W-1:0]    i_pos,
    input  logic [pidl_pkg::ID_W-1:0]     i_prev1,
    input  logic [pidl_pkg::ID_W-1:0]     i_prev2,
    input  logic [pidl_pkg::ID_W-1:0]     i_next1,
    input  logic [pidl_pkg::ID_W-1:0]     i_next2,
    output logic [pidl_pkg::ID_W-1:0]     o_value,
    output logic [pidl_pkg::ID_W-1:0]     o_rd
);
    import pidl_pkg::*;

    localparam int unsigned XW = ((CW + 1) > (POS_W + 1)) ? (CW + 1) : (POS_W + 1);
    localparam logic [XW-1:0] IDX_X = XW'(IDX);

    logic [ID_W-1:0] r_value;
    logic [ID_W-1:0] n_value;
    logic [XW-1:0]   w_at;
    logic [XW-1:0]   w_at1;

    assign w_at  = XW'(i_at);
    assign w_at1 = w_at + XW'(1);

    always_comb begin
        n_value = r_value;
        case (i_ctl.mode)
            CM_INS1: begin
                if (IDX_X > w_at) begin
                    n_value = i_prev1;
                end else if (IDX_X == w_at) begin
                    n_value = i_ctl.id1;
                end
            end
            CM_INS2: begin
                if (IDX_X > w_at1) begin
                    n_value = i_prev2;
                end else if (IDX_X == w_at1) begin
                    n_value = i_ctl.id2;
                end else if (IDX_X == w_at) begin
                    n_value = i_ctl.id1;
                end
            end
            CM_DEL1: begin
                if (IDX_X >= w_at) begin
                    n_value = i_next1;
                end
            end
            CM_DEL2: begin
                if (IDX_X >= w_at) begin
                    n_value = i_next2;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_rd    = (IDX_X == XW'(i_pos)) ? r_value : '0;

endmodule

@@ rtl/pidl_ctrl.sv @@
// ============================================================================
// pidl_ctrl
// Decodes one operation against the entry count into a cell mode and status.
// ============================================================================
module pidl_ctrl #(
    parameter int unsigned CAPACITY = 256,
    parameter int unsigned CW       = 9
) (
    input  logic                             i_accept,
    input  logic [pidl_pkg::FUNC_W-1:0]      i_func,
    input  logic [pidl_pkg::POS_W-1:0]       i_pos,
    input  logic [pidl_pkg::ID_W-1:0]        i_first_id,
    input  logic [pidl_pkg::ID_W-1:0]        i_second_id,
    input  logic [CW-1:0]                    i_count,
    output pidl_pkg::t_cell_ctl              o_ctl,
    output logic [CW-1:0]                    o_at,
    output logic [CW-1:0]                    o_count_next,
    output logic [pidl_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_rd_ok
);
    import pidl_pkg::*;

    localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW:0] CAP_X   = (CW + 1)'(CAPACITY);
    localparam logic [CW:0] CAP_M1  = (CW + 1)'(CAPACITY - 1);

    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt;
    logic          w_in_range;
    logic [CW:0]   w_cnt_x;
    logic [CW:0]   w_next;
    logic [2:0]    w_mode;

    assign w_pos      = PW'(i_pos);
    assign w_cnt      = PW'(i_count);
    assign w_in_range = w_pos < w_cnt;
    assign w_cnt_x    = (CW + 1)'(i_count);
    assign o_at       = w_in_range ? CW'(w_pos) : i_count;

    always_comb begin
        w_mode   = CM_HOLD;
        w_next   = w_cnt_x;
        o_status = ST_DONE;
        o_rd_ok  = 1'b0;
        case (i_func)
            FN_INSERT: begin
                if (w_cnt_x >= CAP_X) begin
                    o_status = ST_FULL;
                end else begin
                    w_mode = CM_INS1;
                    w_next = w_cnt_x + (CW + 1)'(1);
                end
            end
            FN_INSERT2: begin
                if (w_cnt_x >= CAP_M1) begin
                    o_status = ST_FULL;
                end else begin
                    w_mode = CM_INS2;
                    w_next = w_cnt_x + (CW + 1)'(2);
                end
            end
            FN_DELETE: begin
                if (!w_in_range) begin
                    o_status = ST_RANGE;
                end else begin
                    w_mode = CM_DEL1;
                    w_next = w_cnt_x - (CW + 1)'(1);
                end
            end
            FN_DELETE2: begin
                if (!w_in_range) begin
                    o_status = ST_RANGE;
                end else if (w_pos + PW'(1) == w_cnt) begin
                    w_mode = CM_DEL1;
                    w_next = w_cnt_x - (CW + 1)'(1);
                end else begin
                    w_mode = CM_DEL2;
                    w_next = w_cnt_x - (CW + 1)'(2);
                end
            end
            FN_READ: begin
                if (!w_in_range) begin
                    o_status = ST_RANGE;
                end else begin
                    o_rd_ok = 1'b1;
                end
            end
            default: begin
                w_mode = CM_HOLD;
            end
        endcase
    end

    assign o_ctl.mode   = i_accept ? w_mode : CM_HOLD;
    assign o_ctl.id1    = i_first_id;
    assign o_ctl.id2    = i_second_id;
    assign o_count_next = CW'(w_next);

endmodule

@@ rtl/positional_insert_delete_list_unit.sv @@
// ============================================================================
// positional_insert_delete_list_unit
// Ordered list of 32-bit ids with positional insert, delete and read.
// ============================================================================
// Each transaction updates the whole row together: the list lives in a row of CAPACITY
// cells, and an insert or delete moves every cell at once by loading each cell
// from its neighbor one or two places away, so the cost is the decode of the
// entry count plus one cell update; a read is a one-hot select across the row.
// A new transaction is taken in every cycle in which the result register is
// empty or being drained. No clearing pass is needed after reset; the list
// simply starts with a count of zero.
module positional_insert_delete_list_unit #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // func[2:0], pos[10:3], first_id[42:11], second_id[74:43], zero pad
    input  logic [79:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // entry_count[8:0], status[10:9], read_value[42:11], zero pad
    output logic [47:0] o_m_tdata
);
    import pidl_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                    w_accept;
    logic [FUNC_W-1:0]       w_func;
    logic [POS_W-1:0]        w_pos;
    logic [ID_W-1:0]         w_id1;
    logic [ID_W-1:0]         w_id2;
    t_cell_ctl               w_ctl;
    logic [CW-1:0]           w_at;
    logic [CW-1:0]           w_count_next;
    logic [STATUS_W-1:0]     w_status;
    logic                    w_rd_ok;
    logic [ID_W-1:0]         w_ext [CAPACITY+4];
    logic [ID_W-1:0]         w_rd_cell [CAPACITY];
    logic [ID_W-1:0]         w_read;

    logic [CW-1:0]           r_count;
    logic                    r_out_valid;
    logic [OCOUNT_W-1:0]     r_out_count;
    logic [STATUS_W-1:0]     r_out_status;
    logic [ID_W-1:0]         r_out_read;

    assign w_func     = i_s_tdata[2:0];
    assign w_pos      = i_s_tdata[10:3];
    assign w_id1      = i_s_tdata[42:11];
    assign w_id2      = i_s_tdata[74:43];
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    pidl_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_accept     (w_accept),
        .i_func       (w_func),
        .i_pos        (w_pos),
        .i_first_id   (w_id1),
        .i_second_id  (w_id2),
        .i_count      (r_count),
        .o_ctl        (w_ctl),
        .o_at         (w_at),
        .o_count_next (w_count_next),
        .o_status     (w_status),
        .o_rd_ok      (w_rd_ok)
    );

    assign w_ext[0]            = '0;
    assign w_ext[1]            = '0;
    assign w_ext[CAPACITY+2]   = '0;
    assign w_ext[CAPACITY+3]   = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        pidl_cell #(
            .CW  (CW),
            .IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_at    (w_at),
            .i_pos   (w_pos),
            .i_prev1 (w_ext[gi+1]),
            .i_prev2 (w_ext[gi]),
            .i_next1 (w_ext[gi+3]),
            .i_next2 (w_ext[gi+4]),
            .o_value (w_ext[gi+2]),
            .o_rd    (w_rd_cell[gi])
        );
    end

    // transpose the per-cell selections so each read bit is one wide or
    for (genvar gb = 0; gb < ID_W; gb++) begin : g_rd_bit
        logic [CAPACITY-1:0] w_col;
        for (genvar gc = 0; gc < CAPACITY; gc++) begin : g_rd_col
            assign w_col[gc] = w_rd_cell[gc][gb];
        end
        assign w_read[gb] = |w_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= w_count_next;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_count  <= OCOUNT_W'(w_count_next);
            r_out_status <= w_status;
            r_out_read   <= w_rd_ok ? w_read : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_read, r_out_status, r_out_count};

    // the count never passes the capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(CAPACITY) >= r_count)
        else $error("entry count beyond capacity");

    // a failed transaction leaves the count unchanged
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status != ST_DONE) |=> (r_count == $past(r_count)))
        else $error("count moved on a failed transaction");

    // only a successful read reports a nonzero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_rd_ok) |=> (r_out_read == '0))
        else $error("read value on a non-read result");

    // an accepted insert into a full list reports full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == FN_INSERT && r_count == CW'(CAPACITY))
            |-> (w_status == ST_FULL))
        else $error("insert into full list not flagged");

endmodule
